@@ rtl/timed_event_queue_top_macros.svh @@
// assertion helpers for the timed event queue
`ifndef TIMED_EVENT_QUEUE_TOP_MACROS_SVH
`define TIMED_EVENT_QUEUE_TOP_MACROS_SVH

// property that holds whenever reset is released
`define TEQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define TEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/teq_pkg.sv @@
package teq_pkg;
	localparam int QueueDepth = 32;
	localparam int IdxW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam int MsgW = 26;
	localparam int EntryW = 32 + MsgW;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DRAIN  = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_RESET  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_EVENT   = 3'd0,
		KIND_ACCEPT  = 3'd1,
		KIND_DROP    = 3'd2,
		KIND_DRAINED = 3'd3,
		KIND_CLEARED = 3'd4,
		KIND_RESET   = 3'd5
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic            load;       // capture input transaction
		logic            rd_en;
		logic [IdxW-1:0] rd_addr;
		logic            wr_en;
		logic [IdxW-1:0] wr_addr;
		logic            wr_new;     // write the new event rather than the read entry
		logic            div_start;
		logic            cnt_clear;
		logic            cnt_inc;
		logic            cnt_set;    // count <= keep index
		logic            keep_clr;
		logic            keep_inc;
		logic            drop_inc;
		logic            drop_clr;
		logic            out_load;
		kind_t           out_kind;
		logic            out_msg;    // result carries the read entry
		logic            out_off;    // result carries the quotient
		logic            out_last;
	} teq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t            cmd;
		logic [CntW-1:0] count;
		logic [CntW-1:0] keep;       // wide enough to hold a full queue
		logic            rd_gt_new;  // read entry time > new event time
		logic            in_win;
		logic            past;
		logic            note_off;
		logic            div_busy;
		logic            out_busy;
	} teq_sts_t;
endpackage

@@ rtl/teq_ram.sv @@
module teq_ram #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

@@ rtl/teq_div.sv @@
// restoring divider, one quotient bit a cycle
module teq_div import teq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [32:0] den,
	output logic        busy,
	output logic [47:0] quo
);
	logic [5:0]  cnt_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [33:0] trial;

	assign trial = {rem_q, quo_q[47]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
endmodule

@@ rtl/teq_datapath.sv @@
module teq_datapath import teq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  teq_cmd_t    c,
	output teq_sts_t    s,
	input  logic [1:0]  command,
	input  logic [31:0] event_time,
	input  logic [7:0]  status_byte,
	input  logic [7:0]  data_one,
	input  logic [7:0]  data_two,
	input  logic [1:0]  byte_count,
	input  logic [31:0] window_start,
	input  logic [31:0] window_end,
	input  logic [15:0] sample_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  out_status,
	output logic [7:0]  out_data_one,
	output logic [7:0]  out_data_two,
	output logic [1:0]  out_byte_count,
	output logic [15:0] sample_offset,
	output logic [31:0] drop_total,
	output logic        last
);
	logic [1:0]        cmd_q;
	logic [31:0]       time_q, ws_q, we_q;
	logic [MsgW-1:0]   msg_q;
	logic [15:0]       samp_q;
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   keep_q;
	logic [31:0]       drop_q;
	logic [EntryW-1:0] rd_data, wr_data;
	logic [31:0]       rt;
	logic [MsgW-1:0]   rm;
	logic [32:0]       diff, span;
	logic [47:0]       prod_q, quo;
	logic              div_busy;
	logic [15:0]       off_clamp;

	always_ff @(posedge clk) begin
		if (c.load) begin
			cmd_q  <= command;
			time_q <= event_time;
			msg_q  <= {status_byte, data_one, data_two, byte_count};
			ws_q   <= window_start;
			we_q   <= window_end;
			samp_q <= sample_count;
		end
	end

	assign rt = rd_data[EntryW-1:MsgW];
	assign rm = rd_data[MsgW-1:0];
	assign wr_data = c.wr_new ? {time_q, msg_q} : rd_data;

	teq_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ram (
		.clk    (clk),
		.wr_en  (c.wr_en),
		.wr_addr(c.wr_addr),
		.wr_data(wr_data),
		.rd_en  (c.rd_en),
		.rd_addr(c.rd_addr),
		.rd_data(rd_data)
	);

	assign diff = {rt[31], rt} - {ws_q[31], ws_q};
	assign span = {we_q[31], we_q} - {ws_q[31], ws_q};

	// product registered ahead of the divider
	always_ff @(posedge clk) begin
		prod_q <= 48'(diff[31:0]) * 48'(samp_q);
	end

	teq_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (c.div_start),
		.num   (prod_q),
		.den   (span),
		.busy  (div_busy),
		.quo   (quo)
	);

	always_comb begin
		if (samp_q == '0) begin
			off_clamp = '0;
		end else if (quo > 48'(samp_q - 16'd1)) begin
			off_clamp = samp_q - 16'd1;
		end else begin
			off_clamp = quo[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			keep_q  <= '0;
			drop_q  <= '0;
		end else begin
			if (c.cnt_clear) begin
				count_q <= '0;
			end else if (c.cnt_inc) begin
				count_q <= count_q + CntW'(1);
			end else if (c.cnt_set) begin
				count_q <= keep_q;
			end
			if (c.keep_clr) begin
				keep_q <= '0;
			end else if (c.keep_inc) begin
				keep_q <= keep_q + CntW'(1);
			end
			if (c.drop_clr) begin
				drop_q <= '0;
			end else if (c.drop_inc) begin
				drop_q <= drop_q + 32'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (c.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (c.out_load) begin
			kind           <= c.out_kind;
			out_status     <= c.out_msg ? rm[25:18] : '0;
			out_data_one   <= c.out_msg ? rm[17:10] : '0;
			out_data_two   <= c.out_msg ? rm[9:2] : '0;
			out_byte_count <= c.out_msg ? rm[1:0] : '0;
			sample_offset  <= c.out_off ? off_clamp : '0;
			last           <= c.out_last;
		end
	end
	assign drop_total = drop_q;

	assign s.cmd       = cmd_t'(cmd_q);
	assign s.count     = count_q;
	assign s.keep      = keep_q;
	assign s.rd_gt_new = $signed(rt) > $signed(time_q);
	assign s.in_win    = !diff[32] && ($signed(rt) < $signed(we_q));
	assign s.past      = diff[32];
	assign s.note_off  = (rm[25:22] == 4'h8) ||
		(rm[25:22] == 4'h9 && rm[1:0] == 2'd3 && rm[9:2] == 8'd0);
	assign s.div_busy  = div_busy;
	assign s.out_busy  = out_valid && out_stall;
endmodule

@@ rtl/teq_ctrl.sv @@
module teq_ctrl import teq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  teq_sts_t s,
	output teq_cmd_t c
);
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_DEC   = 9'b000000010,
		ST_ISCAN = 9'b000000100,
		ST_IWAIT = 9'b000001000,
		ST_DREAD = 9'b000010000,
		ST_DWAIT = 9'b000100000,
		ST_DMUL  = 9'b001000000,
		ST_DDIV  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t          state_q, state_d;
	logic [CntW-1:0] idx_q, idx_d;
	logic            end_ok;

	assign in_stall = (state_q != ST_IDLE) || s.out_busy;
	assign end_ok = !s.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		c = '0;
		c.out_kind = KIND_EVENT;
		state_d = state_q;
		idx_d = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !s.out_busy) begin
					c.load = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				case (s.cmd)
					CMD_INSERT: begin
						if (s.count >= CntW'(QueueDepth)) begin
							c.drop_inc = 1'b1;
							c.out_load = 1'b1;
							c.out_kind = KIND_DROP;
							c.out_last = 1'b1;
							state_d = ST_IDLE;
						end else begin
							idx_d = s.count;
							state_d = ST_ISCAN;
						end
					end
					CMD_DRAIN: begin
						idx_d = '0;
						c.keep_clr = 1'b1;
						state_d = ST_DREAD;
					end
					CMD_CLEAR: begin
						c.cnt_clear = 1'b1;
						c.out_load = 1'b1;
						c.out_kind = KIND_CLEARED;
						c.out_last = 1'b1;
						state_d = ST_IDLE;
					end
					default: begin
						c.cnt_clear = 1'b1;
						c.drop_clr = 1'b1;
						c.out_load = 1'b1;
						c.out_kind = KIND_RESET;
						c.out_last = 1'b1;
						state_d = ST_IDLE;
					end
				endcase
			end
			// read entry idx-1 and decide in the next cycle, or at idx 0 write the new event
			ST_ISCAN: begin
				if (idx_q == '0) begin
					c.wr_en = 1'b1;
					c.wr_addr = IdxW'(idx_q);
					c.wr_new = 1'b1;
					c.cnt_inc = 1'b1;
					c.out_load = 1'b1;
					c.out_kind = KIND_ACCEPT;
					c.out_last = 1'b1;
					state_d = ST_IDLE;
				end else begin
					c.rd_en = 1'b1;
					c.rd_addr = IdxW'(idx_q - CntW'(1));
					state_d = ST_IWAIT;
				end
			end
			ST_IWAIT: begin
				c.wr_en = 1'b1;
				c.wr_addr = IdxW'(idx_q);
				if (s.rd_gt_new) begin
					idx_d = idx_q - CntW'(1);
					state_d = ST_ISCAN;
				end else begin
					c.wr_new = 1'b1;
					c.cnt_inc = 1'b1;
					c.out_load = 1'b1;
					c.out_kind = KIND_ACCEPT;
					c.out_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_DREAD: begin
				if (idx_q >= s.count) begin
					state_d = ST_DONE;
				end else begin
					c.rd_en = 1'b1;
					c.rd_addr = IdxW'(idx_q);
					state_d = ST_DWAIT;
				end
			end
			ST_DWAIT: begin
				if (s.in_win) begin
					state_d = ST_DMUL;
				end else if (s.past) begin
					if (!s.note_off) begin
						idx_d = idx_q + CntW'(1);
						state_d = ST_DREAD;
					end else if (end_ok) begin
						c.out_load = 1'b1;
						c.out_msg = 1'b1;
						idx_d = idx_q + CntW'(1);
						state_d = ST_DREAD;
					end
				end else begin
					c.wr_en = 1'b1;
					c.wr_addr = IdxW'(s.keep);
					c.keep_inc = 1'b1;
					idx_d = idx_q + CntW'(1);
					state_d = ST_DREAD;
				end
			end
			ST_DMUL: begin
				c.div_start = 1'b1;
				state_d = ST_DDIV;
			end
			ST_DDIV: begin
				if (!s.div_busy && end_ok) begin
					c.out_load = 1'b1;
					c.out_msg = 1'b1;
					c.out_off = 1'b1;
					idx_d = idx_q + CntW'(1);
					state_d = ST_DREAD;
				end
			end
			ST_DONE: begin
				if (end_ok) begin
					c.cnt_set = 1'b1;
					c.out_load = 1'b1;
					c.out_kind = KIND_DRAINED;
					c.out_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

@@ rtl/timed_event_queue_top.sv @@
// insert scans held entries from the tail in ST_ISCAN and ST_IWAIT; clear and reset are answered from ST_DEC
// throughput: one transaction at a time; the 48-step shift divider sets the drain rate
// keep/skip entries pass through ST_DREAD and ST_DWAIT; full-queue drops are answered from ST_DEC
// reset: async active low clears the queue count, drop counter and controller
`include "timed_event_queue_top_macros.svh"
module timed_event_queue_top import teq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] event_time,
	input  logic [7:0]  status_byte,
	input  logic [7:0]  data_one,
	input  logic [7:0]  data_two,
	input  logic [1:0]  byte_count,
	input  logic [31:0] window_start,
	input  logic [31:0] window_end,
	input  logic [15:0] sample_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  out_status,
	output logic [7:0]  out_data_one,
	output logic [7:0]  out_data_two,
	output logic [1:0]  out_byte_count,
	output logic [15:0] sample_offset,
	output logic [31:0] drop_total,
	output logic        last
);
	teq_cmd_t c;
	teq_sts_t s;

	teq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.s       (s),
		.c       (c)
	);

	teq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.c             (c),
		.s             (s),
		.command       (command),
		.event_time    (event_time),
		.status_byte   (status_byte),
		.data_one      (data_one),
		.data_two      (data_two),
		.byte_count    (byte_count),
		.window_start  (window_start),
		.window_end    (window_end),
		.sample_count  (sample_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.out_status    (out_status),
		.out_data_one  (out_data_one),
		.out_data_two  (out_data_two),
		.out_byte_count(out_byte_count),
		.sample_offset (sample_offset),
		.drop_total    (drop_total),
		.last          (last)
	);

	`TEQ_ASSERT(a_count_bound, s.count <= CntW'(QueueDepth), "queue count beyond depth")
	`TEQ_ASSERT_NEXT(a_load_overwrite, c.out_load, out_valid, "result register not loaded")
	`TEQ_ASSERT(a_no_load_when_busy, !(c.out_load && s.out_busy), "result overwritten while stalled")
endmodule

@@ bench/timed_event_queue_top_tb.sv @@
`timescale 1ns / 100ps
module timed_event_queue_top_tb;
	import teq_pkg::*;

	localparam int Depth = QueueDepth;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  status;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [1:0]  bc;
		logic [15:0] offset;
		logic [31:0] drops;
		logic        last;
	} result_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] t;
		logic [7:0]  status;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [1:0]  bc;
		logic [31:0] ws;
		logic [31:0] we;
		logic [15:0] samples;
		logic        typed;   // row carries a typed-in expected kind
		kind_t       want;
	} stim_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] command;
	logic [31:0] event_time, window_start, window_end, drop_total;
	logic [7:0] status_byte, data_one, data_two, out_status, out_data_one, out_data_two;
	logic [1:0] byte_count, out_byte_count;
	logic [15:0] sample_count, sample_offset;
	logic [2:0] kind;
	logic last;

	timed_event_queue_top u_top (.*);

	// predictor state
	logic signed [31:0] q_time [Depth];
	logic [25:0] q_msg [Depth];
	int q_count;
	logic [31:0] q_drops;

	result_t pending_results [$];
	int errors;
	bit calm;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		errors++;
	endtask

	function automatic result_t mk(input logic [2:0] k, input logic [25:0] msg,
			input logic [15:0] off, input logic l);
		result_t r;
		r.kind = k; r.status = msg[25:18]; r.d1 = msg[17:10]; r.d2 = msg[9:2];
		r.bc = msg[1:0]; r.offset = off; r.drops = q_drops; r.last = l;
		return r;
	endfunction

	function automatic bit note_off(input logic [25:0] msg);
		return msg[25:22] == 4'h8 || (msg[25:22] == 4'h9 && msg[1:0] == 2'd3 && msg[9:2] == 0);
	endfunction

	task automatic predict_queue(input stim_t s);
		logic signed [63:0] ws, we, tt;
		logic [63:0] num, den, off;
		logic [25:0] msg;
		int i, w;
		case (s.cmd)
			CMD_INSERT: begin
				if (q_count >= Depth) begin
					q_drops++;
					pending_results.push_back(mk(KIND_DROP, 0, 0, 1));
				end else begin
					msg = {s.status, s.d1, s.d2, s.bc};
					i = q_count;
					while (i > 0 && q_time[i-1] > $signed(s.t)) begin
						q_time[i] = q_time[i-1]; q_msg[i] = q_msg[i-1]; i--;
					end
					q_time[i] = s.t; q_msg[i] = msg; q_count++;
					pending_results.push_back(mk(KIND_ACCEPT, 0, 0, 1));
				end
			end
			CMD_DRAIN: begin
				ws = $signed(s.ws); we = $signed(s.we); w = 0;
				for (i = 0; i < q_count; i++) begin
					tt = q_time[i];
					if (tt >= ws && tt < we) begin
						num = (tt - ws) * s.samples;
						den = we - ws;
						off = num / den;
						if (s.samples == 0) off = 0;
						else if (off > s.samples - 1) off = s.samples - 1;
						pending_results.push_back(mk(KIND_EVENT, q_msg[i], off[15:0], 0));
					end else if (tt < ws) begin
						if (note_off(q_msg[i]))
							pending_results.push_back(mk(KIND_EVENT, q_msg[i], 0, 0));
					end else begin
						q_time[w] = q_time[i]; q_msg[w] = q_msg[i]; w++;
					end
				end
				q_count = w;
				pending_results.push_back(mk(KIND_DRAINED, 0, 0, 1));
			end
			CMD_CLEAR: begin
				q_count = 0;
				pending_results.push_back(mk(KIND_CLEARED, 0, 0, 1));
			end
			default: begin
				q_count = 0; q_drops = 0;
				pending_results.push_back(mk(KIND_RESET, 0, 0, 1));
			end
		endcase
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result side
	int rx_idle;
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_idle = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report("unexpected result", kind, 0);
				end else begin
					exp_r = pending_results.pop_front();
					if (kind != exp_r.kind) report("kind", kind, exp_r.kind);
					if (out_status != exp_r.status) report("status", out_status, exp_r.status);
					if (out_data_one != exp_r.d1) report("data_one", out_data_one, exp_r.d1);
					if (out_data_two != exp_r.d2) report("data_two", out_data_two, exp_r.d2);
					if (out_byte_count != exp_r.bc) report("byte_count", out_byte_count, exp_r.bc);
					if (sample_offset != exp_r.offset) report("offset", sample_offset, exp_r.offset);
					if (drop_total != exp_r.drops) report("drop_total", drop_total, exp_r.drops);
					if (last != exp_r.last) report("last", last, exp_r.last);
				end
			end
			if (rx_idle > 0) begin
				rx_idle--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rx_idle = $urandom_range(1, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// valid stays high from one transaction to the next unless a gap is taken
	task automatic send(input stim_t s, input bit gaps);
		int g;
		if (gaps && $urandom_range(0, 5) == 0) begin
			g = $urandom_range(1, 10);
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		command <= s.cmd; event_time <= s.t; status_byte <= s.status;
		data_one <= s.d1; data_two <= s.d2; byte_count <= s.bc;
		window_start <= s.ws; window_end <= s.we; sample_count <= s.samples;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (s.typed) begin
			predict_queue(s);
			if (pending_results[$].kind != s.want) report("typed kind", pending_results[$].kind, s.want);
		end else begin
			predict_queue(s);
		end
	endtask

	function automatic stim_t row(input cmd_t c, input logic [31:0] t, input logic [7:0] st,
			input logic [7:0] a, input logic [7:0] b, input logic [1:0] bc,
			input logic [31:0] ws, input logic [31:0] we, input logic [15:0] n,
			input bit typed, input kind_t want);
		stim_t s;
		s.cmd = c; s.t = t; s.status = st; s.d1 = a; s.d2 = b; s.bc = bc;
		s.ws = ws; s.we = we; s.samples = n; s.typed = typed; s.want = want;
		return s;
	endfunction

	function automatic logic [31:0] rand_time(input int mode);
		case (mode)
			0: return $urandom();
			1: return 32'(int'($urandom_range(0, 8 << 16)) - (2 << 16));
			default: return 32'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic stim_t rand_item();
		stim_t s;
		int pick, mode;
		logic [31:0] a, b;
		pick = $urandom_range(0, 99);
		mode = $urandom_range(0, 9) == 0 ? 0 : 1;
		s.cmd = pick < 62 ? CMD_INSERT : pick < 92 ? CMD_DRAIN : pick < 97 ? CMD_CLEAR : CMD_RESET;
		s.t = rand_time(mode);
		s.status = $urandom_range(0, 3) == 0 ? 8'($urandom_range(8'h80, 8'h9f)) : 8'($urandom());
		s.d1 = 8'($urandom()); s.d2 = $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom());
		s.bc = 2'($urandom());
		a = rand_time(mode); b = rand_time(mode);
		if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
			s.ws = b; s.we = a;
		end else begin
			s.ws = a; s.we = b;
		end
		s.samples = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 512));
		s.typed = 0; s.want = KIND_EVENT;
		return s;
	endfunction

	stim_t directed [$];

	initial begin
		int i, spin;
		errors = 0; calm = 0;
		q_count = 0; q_drops = 0;
		in_valid = 0; command = 0; event_time = 0; status_byte = 0; data_one = 0;
		data_two = 0; byte_count = 0; window_start = 0; window_end = 0; sample_count = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		directed.push_back(row(CMD_DRAIN, 0, 0, 0, 0, 0, 0, 32'h10000, 100, 1, KIND_DRAINED));
		directed.push_back(row(CMD_INSERT, 32'h80000000, 8'h90, 8'd60, 8'd0, 2'd3, 0, 0, 0, 1, KIND_ACCEPT));
		directed.push_back(row(CMD_INSERT, 32'h7fffffff, 8'hff, 8'hff, 8'hff, 2'd0, 0, 0, 0, 1, KIND_ACCEPT));
		directed.push_back(row(CMD_INSERT, 32'h8000, 8'h80, 8'd1, 8'd2, 2'd3, 0, 0, 0, 1, KIND_ACCEPT));
		directed.push_back(row(CMD_INSERT, 32'h8000, 8'h00, 8'd0, 8'd0, 2'd1, 0, 0, 0, 1, KIND_ACCEPT));
		directed.push_back(row(CMD_INSERT, 32'h4000, 8'hb0, 8'd7, 8'd9, 2'd2, 0, 0, 0, 1, KIND_ACCEPT));
		directed.push_back(row(CMD_INSERT, 32'hffff0000, 8'h95, 8'd3, 8'd0, 2'd2, 0, 0, 0, 1, KIND_ACCEPT));
		// inverted window: only past entries are handled
		directed.push_back(row(CMD_DRAIN, 0, 0, 0, 0, 0, 32'h0, 32'hfff00000, 8, 0, KIND_EVENT));
		directed.push_back(row(CMD_DRAIN, 0, 0, 0, 0, 0, 32'h0, 32'h10000, 16'hffff, 0, KIND_EVENT));
		directed.push_back(row(CMD_INSERT, 32'h100, 8'h92, 8'd1, 8'd1, 2'd3, 0, 0, 0, 1, KIND_ACCEPT));
		// zero sample count forces offset zero
		directed.push_back(row(CMD_DRAIN, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0, 0, KIND_EVENT));
		directed.push_back(row(CMD_INSERT, 32'h100, 8'h92, 8'd1, 8'd1, 2'd3, 0, 0, 0, 1, KIND_ACCEPT));
		directed.push_back(row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, KIND_CLEARED));
		foreach (directed[k]) send(directed[k], 0);

		// fill past capacity for drops, then whole-range drain
		for (i = 0; i < Depth + 3; i++)
			send(row(CMD_INSERT, rand_time(1), 8'($urandom()), 8'($urandom()), 8'($urandom()),
				2'($urandom()), 0, 0, 0, 0, KIND_EVENT), 1);
		send(row(CMD_DRAIN, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 16'hffff, 0, KIND_EVENT), 1);
		send(row(CMD_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 1, KIND_RESET), 1);

		// sender holds off until the queue of results is empty or the spin limit runs out
		in_valid <= 1'b0;
		@(posedge clk);
		spin = 0;
		while (pending_results.size() != 0 && spin < 100000) begin
			@(posedge clk); spin++;
		end

		for (i = 0; i < 330; i++) begin
			if (i == 290) calm = 1;
			send(rand_item(), !calm);
		end
		in_valid <= 1'b0;

		spin = 0;
		while (pending_results.size() != 0 && spin < 200000) begin
			@(posedge clk); spin++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("timed_event_queue_top verification clean");
		else
			$display("timed_event_queue_top verification failed");
		$finish;
	end

	initial begin
		#100ms;
		$display("timed_event_queue_top verification failed");
		$finish;
	end
endmodule
